// File: rtl/iptb_pkg.sv
// Package for the identity page table builder: widths, flag words, status codes,
// sequencer states and the entry unit control struct.
// No dependencies.
`default_nettype none

package iptb_pkg;

   localparam int POOL_PAGES_DEF    = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = 9;
   localparam int ADDR_W            = 48;
   localparam int ENTRY_W           = 64;
   localparam int PAGE_FIELD_W      = 6;
   localparam int STATUS_W          = 2;
   localparam int TUSED_W           = 7;
   localparam int PFN_W             = 20;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_ADDR_W        = 3;
   localparam int LEVEL_W           = 2;

   localparam logic [11:0]           DIR_FLAGS        = 12'h023;
   localparam logic [11:0]           UNCACHED_FLAGS   = 12'h018;
   localparam logic [CSR_DATA_W-1:0] TABLE_BASE_RESET = 32'h0010_0000;

   // register index, taken from paddr[2]
   localparam logic REG_TABLE_BASE = 1'b0;

   // request commands
   localparam logic CMD_MAP  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ROOT_IDX = 2'd1;
   localparam logic [STATUS_W-1:0] ST_POOL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_LOW_PAGE = 2'd3;

   localparam logic [LEVEL_W-1:0] LEVEL_ROOT = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_PDPT = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_DIR  = 2'd2;

   typedef enum logic [1:0] {
      ENT_CLEAR,
      ENT_DIR,
      ENT_LEAF,
      ENT_FILL
   } ent_mode_type;

   typedef struct packed {
      ent_mode_type      mode;
      logic [11:0]       flags;
      logic [IDX_W-1:0]  index;
   } ent_ctrl_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_READ_ISSUE,
      S_READ_DATA,
      S_WALK_ISSUE,
      S_WALK_EVAL,
      S_LEAF,
      S_FILL,
      S_FILL_TAIL,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// File: rtl/iptb_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on iptb_pkg.
`default_nettype none

interface iptb_req_if;
   import iptb_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic [ADDR_W-1:0]       address;
   logic                    cached;
   logic                    one_page;
   logic [PAGE_FIELD_W-1:0] table_page;
   logic [IDX_W-1:0]        entry_index;

   modport source (output valid, command, address, cached, one_page, table_page,
                   entry_index, input ready);
   modport sink   (input valid, command, address, cached, one_page, table_page,
                   entry_index, output ready);
endinterface

interface iptb_rsp_if;
   import iptb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [ENTRY_W-1:0]   entry_value;
   logic [TUSED_W-1:0]   tables_used;

   modport source (output valid, status, entry_value, tables_used, input ready);
   modport sink   (input valid, status, entry_value, tables_used, output ready);
endinterface

`default_nettype wire

// File: rtl/iptb_table_mem.sv
// Table page pool: one write port and one read port, registered read data.
// Depends on iptb_pkg.
`default_nettype none

module iptb_table_mem #(
   parameter int POOL_PAGES = iptb_pkg::POOL_PAGES_DEF
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [$clog2(POOL_PAGES)+iptb_pkg::IDX_W-1:0] wr_addr,
   input  wire logic [iptb_pkg::ENTRY_W-1:0]                  wr_data,
   input  wire logic                                          rd_en,
   input  wire logic [$clog2(POOL_PAGES)+iptb_pkg::IDX_W-1:0] rd_addr,
   output      logic [iptb_pkg::ENTRY_W-1:0]                  rd_data
);
   import iptb_pkg::*;

   localparam int DEPTH = POOL_PAGES * ENTRIES_PER_TABLE;

   logic [ENTRY_W-1:0] mem_ff [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/iptb_entry_unit.sv
// Shared entry arithmetic: builds every word written to the pool and turns a
// present pointer back into a pool page number. Depends on iptb_pkg.
`default_nettype none

module iptb_entry_unit #(
   parameter int POOL_PAGES = iptb_pkg::POOL_PAGES_DEF
) (
   input  wire iptb_pkg::ent_ctrl_type                 ctrl,
   input  wire logic [iptb_pkg::PFN_W-1:0]             base_pfn,
   input  wire logic [$clog2(POOL_PAGES)-1:0]          new_page,
   input  wire logic [iptb_pkg::ADDR_W-1:0]            address,
   input  wire logic [iptb_pkg::ENTRY_W-1:0]           old_entry,
   output      logic [iptb_pkg::ENTRY_W-1:0]           wr_data,
   output      logic [iptb_pkg::PFN_W-1:0]             ptr_page
);
   import iptb_pkg::*;

   logic [PFN_W:0] new_pfn;

   // pool page address: base frame plus page number
   assign new_pfn  = {1'b0, base_pfn} + (PFN_W+1)'(new_page);
   // pointer back to page number, wraps modulo 2^20 like the frame field
   assign ptr_page = old_entry[31:12] - base_pfn;

   always_comb begin
      case (ctrl.mode)
         ENT_CLEAR: wr_data = '0;
         ENT_DIR:   wr_data = {31'b0, new_pfn, DIR_FLAGS};
         ENT_LEAF:  wr_data = {16'b0, address[47:12], ctrl.flags};
         ENT_FILL:  wr_data = {16'b0, address[47:21], ctrl.index,
                               old_entry[11:0] | ctrl.flags};
         default:   wr_data = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/identity_page_table_builder.sv
// Identity page table builder, top level; depends on iptb_pkg, iptb_if, iptb_table_mem
// and iptb_entry_unit. Responses cover a rejected map, a read, a walk that stops at level
// 1/2/3, a walk plus leaf write and a 2 MiB fill. One transaction at a time: the next is
// taken in the cycle after the response loads; an unaccepted response stalls the end.
// Synchronous reset, then a clearing pass over all POOL_PAGES*512 entries, req not ready.
`default_nettype none

module identity_page_table_builder #(
   parameter int POOL_PAGES = iptb_pkg::POOL_PAGES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   iptb_req_if.sink                               req_chan,
   iptb_rsp_if.source                             rsp_chan,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [iptb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [iptb_pkg::CSR_DATA_W-1:0]   pwdata,
   output      logic [iptb_pkg::CSR_DATA_W-1:0]   prdata,
   output      logic                              pready
);
   import iptb_pkg::*;

   localparam int PAGE_W = $clog2(POOL_PAGES);
   localparam int MEM_AW = PAGE_W + IDX_W;
   localparam int CNT_W  = $clog2(POOL_PAGES + 1);
   localparam int DEPTH  = POOL_PAGES * ENTRIES_PER_TABLE;

   // ---------------------------------------------------------------- registers
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   address_ff, address_in;
   logic [11:0]         flags_ff, flags_in;
   logic                single_ff, single_in;
   logic [PAGE_W-1:0]   rd_page_ff, rd_page_in;
   logic [IDX_W-1:0]    rd_index_ff, rd_index_in;
   logic [PAGE_W-1:0]   cur_page_ff, cur_page_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [CNT_W-1:0]    nfp_ff, nfp_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ENTRY_W-1:0]  value_ff, value_in;
   logic [IDX_W-1:0]    fill_idx_ff, fill_idx_in;
   logic                fill_wv_ff, fill_wv_in;
   logic [IDX_W-1:0]    fill_widx_ff, fill_widx_in;
   logic [MEM_AW-1:0]   clr_addr_ff, clr_addr_in;
   logic [CSR_DATA_W-1:0] table_base_ff, table_base_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [TUSED_W-1:0]  rsp_used_ff, rsp_used_in;

   // ---------------------------------------------------------------- datapath nets
   logic                mem_wr_en, mem_rd_en;
   logic [MEM_AW-1:0]   mem_wr_addr, mem_rd_addr;
   logic [ENTRY_W-1:0]  mem_wr_data, mem_rd_data;
   ent_ctrl_type        ent_ctrl;
   logic [PFN_W-1:0]    ptr_page;
   logic [IDX_W-1:0]    walk_idx;
   logic                rsp_load;
   logic                csr_write;

   // ---------------------------------------------------------------- config port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign prdata    = (paddr[2] == REG_TABLE_BASE) ? table_base_ff : '0;

   always_comb begin
      table_base_in = table_base_ff;
      if (csr_write && paddr[2] == REG_TABLE_BASE) begin
         table_base_in = pwdata;
      end
   end

   // ---------------------------------------------------------------- pool and entry unit
   iptb_table_mem #(.POOL_PAGES(POOL_PAGES)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   iptb_entry_unit #(.POOL_PAGES(POOL_PAGES)) u_entry (
      .ctrl      (ent_ctrl),
      .base_pfn  (table_base_ff[31:12]),
      .new_page  (PAGE_W'(nfp_ff)),
      .address   (address_ff),
      .old_entry (mem_rd_data),
      .wr_data   (mem_wr_data),
      .ptr_page  (ptr_page)
   );

   // index into the table at the current walk level
   always_comb begin
      case (level_ff)
         LEVEL_ROOT: walk_idx = address_ff[47:39];
         LEVEL_PDPT: walk_idx = address_ff[38:30];
         default:    walk_idx = address_ff[29:21];
      endcase
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      address_in   = address_ff;
      flags_in     = flags_ff;
      single_in    = single_ff;
      rd_page_in   = rd_page_ff;
      rd_index_in  = rd_index_ff;
      cur_page_in  = cur_page_ff;
      level_in     = level_ff;
      nfp_in       = nfp_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      fill_idx_in  = fill_idx_ff;
      fill_wv_in   = 1'b0;
      fill_widx_in = fill_widx_ff;
      clr_addr_in  = clr_addr_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = {cur_page_ff, walk_idx};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = {cur_page_ff, walk_idx};
      ent_ctrl     = '{mode: ENT_DIR, flags: flags_ff, index: fill_widx_ff};
      req_chan.ready = 1'b0;
      rsp_load     = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = clr_addr_ff;
            ent_ctrl.mode = ENT_CLEAR;
            clr_addr_in   = clr_addr_ff + 1'b1;
            if (clr_addr_ff == MEM_AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               address_in  = req_chan.address;
               single_in   = req_chan.one_page;
               flags_in    = req_chan.cached ? DIR_FLAGS : (DIR_FLAGS | UNCACHED_FLAGS);
               rd_page_in  = PAGE_W'(req_chan.table_page);
               rd_index_in = req_chan.entry_index;
               status_in   = ST_OK;
               value_in    = '0;
               level_in    = LEVEL_ROOT;
               cur_page_in = '0;
               if (req_chan.command == CMD_READ) begin
                  // pages beyond the pool read as zero
                  if (11'(req_chan.table_page) < 11'(POOL_PAGES)) begin
                     state_in = S_READ_ISSUE;
                  end else begin
                     state_in = S_DONE;
                  end
               end else if (req_chan.one_page && req_chan.address[47:12] == '0) begin
                  status_in = ST_LOW_PAGE;
                  state_in  = S_DONE;
               end else if (req_chan.address[47]) begin
                  // root index above 255
                  status_in = ST_ROOT_IDX;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_WALK_ISSUE;
               end
            end
         end

         S_READ_ISSUE: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = {rd_page_ff, rd_index_ff};
            state_in    = S_READ_DATA;
         end

         S_READ_DATA: begin
            value_in = mem_rd_data;
            state_in = S_DONE;
         end

         S_WALK_ISSUE: begin
            mem_rd_en = 1'b1;
            state_in  = S_WALK_EVAL;
         end

         S_WALK_EVAL: begin
            ent_ctrl.mode = ENT_DIR;
            if (mem_rd_data[0] && ptr_page >= PFN_W'(POOL_PAGES)) begin
               // present but names no pool page: stale pointer
               status_in = ST_POOL;
               state_in  = S_DONE;
            end else if (!mem_rd_data[0] && nfp_ff >= CNT_W'(POOL_PAGES)) begin
               status_in = ST_POOL;
               state_in  = S_DONE;
            end else begin
               if (mem_rd_data[0]) begin
                  cur_page_in = PAGE_W'(ptr_page);
               end else begin
                  // allocate the next pool page and link it in
                  mem_wr_en   = 1'b1;
                  cur_page_in = PAGE_W'(nfp_ff);
                  nfp_in      = nfp_ff + 1'b1;
               end
               if (level_ff == LEVEL_DIR) begin
                  if (single_ff) begin
                     state_in = S_LEAF;
                  end else begin
                     // region at address zero keeps page zero unmapped
                     fill_idx_in = (address_ff[47:21] == '0) ? IDX_W'(1) : '0;
                     state_in    = S_FILL;
                  end
               end else begin
                  level_in = level_ff + 1'b1;
                  state_in = S_WALK_ISSUE;
               end
            end
         end

         S_LEAF: begin
            ent_ctrl.mode = ENT_LEAF;
            mem_wr_en     = 1'b1;
            mem_wr_addr   = {cur_page_ff, address_ff[20:12]};
            state_in      = S_DONE;
         end

         S_FILL: begin
            // read entry i while entry i-1 is written back
            mem_rd_en    = 1'b1;
            mem_rd_addr  = {cur_page_ff, fill_idx_ff};
            fill_wv_in   = 1'b1;
            fill_widx_in = fill_idx_ff;
            fill_idx_in  = fill_idx_ff + 1'b1;
            if (fill_idx_ff == IDX_W'(ENTRIES_PER_TABLE - 1)) begin
               state_in = S_FILL_TAIL;
            end
         end

         S_FILL_TAIL: begin
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // fill write-back, in the cycle after its read
      if (fill_wv_ff) begin
         ent_ctrl.mode  = ENT_FILL;
         ent_ctrl.index = fill_widx_ff;
         mem_wr_en      = 1'b1;
         mem_wr_addr    = {cur_page_ff, fill_widx_ff};
      end
   end

   // ---------------------------------------------------------------- response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_used_in   = rsp_used_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_value_in  = value_ff;
         rsp_used_in   = TUSED_W'(nfp_ff);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_value = rsp_value_ff;
   assign rsp_chan.tables_used = rsp_used_ff;

   // ---------------------------------------------------------------- state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         nfp_ff        <= CNT_W'(1);
         clr_addr_ff   <= '0;
         fill_wv_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         table_base_ff <= TABLE_BASE_RESET;
      end else begin
         state_ff      <= state_in;
         nfp_ff        <= nfp_in;
         clr_addr_ff   <= clr_addr_in;
         fill_wv_ff    <= fill_wv_in;
         rsp_valid_ff  <= rsp_valid_in;
         table_base_ff <= table_base_in;
      end
   end

   always_ff @(posedge clock) begin
      address_ff    <= address_in;
      flags_ff      <= flags_in;
      single_ff     <= single_in;
      rd_page_ff    <= rd_page_in;
      rd_index_ff   <= rd_index_in;
      cur_page_ff   <= cur_page_in;
      level_ff      <= level_in;
      status_ff     <= status_in;
      value_ff      <= value_in;
      fill_idx_ff   <= fill_idx_in;
      fill_widx_ff  <= fill_widx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // ---------------------------------------------------------------- assertions
   // allocation never runs past the pool
   a_nfp_bound: assert property (@(posedge clock) disable iff (reset)
      nfp_ff <= CNT_W'(POOL_PAGES))
      else $error("page count beyond pool");

   // allocated pages are never handed back
   a_nfp_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> nfp_ff >= $past(nfp_ff))
      else $error("page count went down");

   // pool is never written while waiting for a transaction
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !mem_wr_en)
      else $error("pool write while idle");

endmodule

`default_nettype wire
